@@ src/ubrf_pkg.sv @@
`timescale 1ns / 1ps
package ubrf_pkg;

  // Stream and table geometry
  localparam int POS_BITS_DEF = 32;
  localparam int BYTE_VALS    = 256;
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 9;
  localparam int OFFS_W       = 32;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 48;

  // Configuration port
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam logic [LEN_W-1:0] MIN_RUN_RST = 9'd256;

  // Register index codes (word address)
  localparam logic REG_MIN_RUN = 1'b0;

  // One reported run
  typedef struct packed {
    logic [OFFS_W-1:0] run_offset;
    logic [LEN_W-1:0]  run_length;
    logic              final_result;
  } ubrf_res_t;

  // Results handed from the scanner to the result queue in the same cycle
  typedef struct packed {
    logic [1:0] cnt;
    ubrf_res_t  res0;
    ubrf_res_t  res1;
  } ubrf_push_t;

endpackage

@@ src/ubrf_ram.sv @@
`timescale 1ns / 1ps
module ubrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; a read of the same address in the same cycle sees old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/ubrf_core.sv @@
`timescale 1ns / 1ps
module ubrf_core import ubrf_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_eos,
  output logic              in_ready,
  input  logic [LEN_W-1:0]  min_run,
  input  logic [1:0]        free_slots,
  output ubrf_push_t        push
);

  localparam int AW = $clog2(BYTE_VALS);

  logic                s1_vld_r;
  logic [AW-1:0]       s1_byte_r;
  logic                s1_eos_r;
  logic                fwd_hit_r;
  logic [POS_BITS-1:0] fwd_pos_r;
  logic [BYTE_VALS-1:0] seen_r;
  logic [POS_BITS-1:0] pos_r;
  logic [POS_BITS-1:0] start_r;

  logic                accept;
  logic                commit;
  logic [POS_BITS-1:0] ram_rd;
  logic [POS_BITS-1:0] last_pos;
  logic [POS_BITS-1:0] run_len;
  logic [POS_BITS-1:0] q_dist;
  logic [POS_BITS-1:0] min_ext;
  logic [POS_BITS-1:0] pos_nxt;
  logic [POS_BITS-1:0] start_nxt;
  logic [POS_BITS-1:0] flush_len;
  logic                hit;
  logic                rep;
  logic                flush;
  logic [1:0]          need;

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_vld_r || commit;

  // Last position of each byte value
  ubrf_ram #(
    .WIDTH (POS_BITS),
    .DEPTH (BYTE_VALS)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (s1_byte_r),
    .wr_data (pos_r),
    .rd_en   (accept),
    .rd_addr (in_byte[AW-1:0]),
    .rd_data (ram_rd)
  );

  // Take the write of the committing byte in place of the stale read
  assign last_pos = fwd_hit_r ? fwd_pos_r : ram_rd;

  // Judge the repeat and the run boundaries
  always_comb begin
    min_ext   = POS_BITS'(min_run);
    run_len   = pos_r - start_r;
    q_dist    = last_pos - start_r;
    hit       = seen_r[s1_byte_r] && (q_dist < run_len);
    rep       = hit && (run_len >= min_ext);
    pos_nxt   = pos_r + POS_BITS'(1);
    // Open run length after this byte, taken per start candidate in parallel
    if (rep) begin
      start_nxt = pos_r;
      flush_len = POS_BITS'(1);
    end else if (hit) begin
      start_nxt = last_pos + POS_BITS'(1);
      flush_len = pos_r - last_pos;
    end else begin
      start_nxt = start_r;
      flush_len = pos_nxt - start_r;
    end
    flush     = s1_eos_r && (flush_len >= min_ext);
    need      = {1'b0, rep} + {1'b0, flush};
    commit    = s1_vld_r && (need <= free_slots);
  end

  // Hand results to the queue
  always_comb begin
    push.cnt = commit ? need : 2'd0;
    if (rep) begin
      push.res0.run_offset = OFFS_W'(start_r);
      push.res0.run_length = run_len[LEN_W-1:0];
    end else begin
      push.res0.run_offset = OFFS_W'(start_nxt);
      push.res0.run_length = flush_len[LEN_W-1:0];
    end
    push.res0.final_result = !(rep && flush);
    push.res1.run_offset   = OFFS_W'(start_nxt);
    push.res1.run_length   = flush_len[LEN_W-1:0];
    push.res1.final_result = 1'b1;
  end

  // Stage register and forwarding capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_r  <= 1'b1;
        fwd_hit_r <= commit && (s1_byte_r == in_byte[AW-1:0]);
      end else if (commit) begin
        s1_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_byte[AW-1:0];
      s1_eos_r  <= in_eos;
      fwd_pos_r <= pos_r;
    end
  end

  // Advance the scan state; clear it all at end of stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      pos_r   <= '0;
      start_r <= '0;
    end else if (commit) begin
      if (s1_eos_r) begin
        seen_r  <= '0;
        pos_r   <= '0;
        start_r <= '0;
      end else begin
        seen_r[s1_byte_r] <= 1'b1;
        pos_r             <= pos_nxt;
        start_r           <= start_nxt;
      end
    end
  end

endmodule

@@ src/ubrf_outq.sv @@
`timescale 1ns / 1ps
module ubrf_outq import ubrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ubrf_push_t push,
  output logic [1:0] free_slots,
  output logic       out_valid,
  input  logic       out_ready,
  output ubrf_res_t  out_res
);

  logic [1:0] cnt_r;
  ubrf_res_t  ent_r [2];
  logic [1:0] cnt_nxt;
  ubrf_res_t  ent_nxt [2];
  logic       pop;
  logic [1:0] cnt_left;

  assign pop        = (cnt_r != 2'd0) && out_ready;
  assign out_valid  = (cnt_r != 2'd0);
  assign out_res    = ent_r[0];
  assign free_slots = 2'd2 - cnt_r + {1'b0, pop};

  // Drop the head on a transaction, then append new results
  always_comb begin
    ent_nxt[0] = ent_r[0];
    ent_nxt[1] = ent_r[1];
    cnt_left   = cnt_r;
    if (pop) begin
      ent_nxt[0] = ent_r[1];
      cnt_left   = cnt_r - 2'd1;
    end
    if (push.cnt != 2'd0) begin
      ent_nxt[cnt_left[0]] = push.res0;
    end
    if (push.cnt == 2'd2) begin
      ent_nxt[1] = push.res1;
    end
    cnt_nxt = cnt_left + push.cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
  end

endmodule

@@ src/unique_byte_run_finder.sv @@
`timescale 1ns / 1ps
// Unique byte run finder.
// Input stream: one byte per transaction in in_tdata, in_tlast marks the
// last byte of an image. Output stream: one reported run per transaction,
// offset and length in out_tdata; out_tlast marks the last run caused by
// one input byte. A byte causes zero, one or two runs.
// Throughput: one byte per cycle while the result queue has room for the
// byte's runs; the position table is a one-port-read, one-port-write RAM
// touched once per byte, with a forward from the write of the byte ahead.
// A byte that yields two runs occupies two output transactions. A run
// is registered in the scanner stage and then in the result queue.
// A two-entry result queue parts the sides: in_tready stays high while
// out_tready is low until the queue lacks room for the pending byte's runs.
// Configuration: register 0 (byte address 0) holds min_run_length, reset
// 256; write it only while the block is idle.
// Reset (synchronous, rst_n low): scan position, run start and all
// seen flags clear at once; no clearing pass runs. The same clearing
// happens after the byte marked by in_tlast.
module unique_byte_run_finder import ubrf_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] run_offset, [40:32] run_length
  output logic                   out_tlast,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [LEN_W-1:0] min_run_r;
  logic [1:0]       free_slots;
  ubrf_push_t       push;
  ubrf_res_t        out_res;

  // Configuration register
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_run_r <= MIN_RUN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == REG_MIN_RUN)) begin
      min_run_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_MIN_RUN) ? CFG_DW'(min_run_r) : '0;

  // Scanner around the position table
  ubrf_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata[BYTE_W-1:0]),
    .in_eos     (in_tlast),
    .in_ready   (in_tready),
    .min_run    (min_run_r),
    .free_slots (free_slots),
    .push       (push)
  );

  // Result queue
  ubrf_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .free_slots (free_slots),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {(OUT_TDATA_W - OFFS_W - LEN_W)'(0), out_res.run_length,
                      out_res.run_offset};
  assign out_tlast = out_res.final_result;

endmodule

@@ src/ubrf_chk.sv @@
`timescale 1ns / 1ps
module ubrf_chk import ubrf_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // Padding above run_length stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:OFFS_W+LEN_W] == '0))
    else $error("nonzero padding in result");

  // Reset flushes pending results
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind unique_byte_run_finder ubrf_chk u_ubrf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ tb/tb_unique_byte_run_finder.sv @@
`timescale 1ns / 1ps
module tb_unique_byte_run_finder;
  import ubrf_pkg::*;

  // Byte address of the threshold register, and one past the register map
  localparam logic [CFG_AW-1:0] ADDR_MIN_RUN = {REG_MIN_RUN, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED = 3'd4;
  localparam int SETTLE_CYCLES = 8;
  localparam longint RUN_LIMIT_NS = 20_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] data_byte
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] run_offset, [40:32] run_length
  logic                   out_tlast;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // Scanner state mirrored by the testbench
  logic [31:0]      seen_at [256];
  logic             seen [256];
  logic [31:0]      scan_pos;
  logic [31:0]      run_begin;
  logic [LEN_W-1:0] min_run;
  ubrf_res_t        runs_pending [$];

  int   errors = 0;
  bit   idle_on = 1'b0;
  int   stall_left = 0;

  unique_byte_run_finder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Clear the scan state as reset and end of stream do
  task automatic clear_scan();
    for (int i = 0; i < 256; i++) seen[i] = 1'b0;
    scan_pos = '0;
    run_begin = '0;
  endtask

  // Advance the mirrored scanner by one byte and queue the runs it reports
  task automatic predict_runs(input logic [7:0] b, input logic eos);
    logic [31:0] pos;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] flush_len;
    ubrf_res_t   found [2];
    int          n;
    n = 0;
    pos = scan_pos;
    start = run_begin;
    len = pos - start;
    // A repeat inside the open run ends it
    if (seen[b] && (seen_at[b] - start) < len) begin
      if (len >= 32'(min_run)) begin
        found[n] = '{run_offset: start, run_length: len[LEN_W-1:0], final_result: 1'b0};
        n++;
        start = pos;
      end else begin
        start = seen_at[b] + 32'd1;
      end
    end
    seen_at[b] = pos;
    seen[b] = 1'b1;
    run_begin = start;
    scan_pos = pos + 32'd1;
    // Flush the open run at end of stream
    if (eos) begin
      flush_len = scan_pos - start;
      if (flush_len >= 32'(min_run)) begin
        found[n] = '{run_offset: start, run_length: flush_len[LEN_W-1:0],
                     final_result: 1'b0};
        n++;
      end
      clear_scan();
    end
    for (int i = 0; i < n; i++) begin
      found[i].final_result = (i == n - 1);
      runs_pending.push_back(found[i]);
    end
  endtask

  // Offer one byte, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    predict_runs(b, eos);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop the input and let every expected run and any silent byte drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (runs_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] val);
    wait_idle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_MIN_RUN) min_run = val[LEN_W-1:0];
  endtask

  // Repeats inside and outside the run, both byte extremes
  task automatic test_basic_runs();
    write_reg(ADDR_MIN_RUN, 32'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  // Zero threshold: a repeat run and a flush run from one byte
  task automatic test_two_results();
    write_reg(ADDR_MIN_RUN, 32'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h12, 1'b1);
  endtask

  // Short run moves its start just past the earlier occurrence
  task automatic test_short_run_skip();
    write_reg(ADDR_MIN_RUN, 32'd3);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  // Threshold above 256 never reports; a write past the map changes nothing
  task automatic test_high_threshold();
    write_reg(ADDR_MIN_RUN, 32'd300);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h07, 1'b1);
    write_reg(ADDR_UNMAPPED, 32'd1);
    send_byte(8'h09, 1'b0);
    send_byte(8'h09, 1'b1);
  endtask

  // Frames of random length over random alphabets; some frames run on
  task automatic test_random_frames(input logic [CFG_DW-1:0] threshold, input int n_items,
                                    input bit with_idle);
    int         sent;
    int         frame_len;
    int         alph_bits;
    logic [7:0] base;
    logic       eos;
    write_reg(ADDR_MIN_RUN, threshold);
    idle_on = with_idle;
    sent = 0;
    while (sent < n_items) begin
      frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 40);
      // Keep the byte count of this test at its budget
      if (frame_len > n_items - sent) frame_len = n_items - sent;
      alph_bits = $urandom_range(1, 8);
      base = 8'($urandom_range(0, 255));
      for (int i = 0; i < frame_len; i++) begin
        eos = (i == frame_len - 1) && ($urandom_range(0, 4) != 0);
        send_byte(base ^ 8'($urandom_range(0, (1 << alph_bits) - 1)), eos);
        sent++;
      end
    end
  endtask

  // Runs of all 256 values, ended once by a repeat and once by a flush
  task automatic test_full_width_runs();
    logic [7:0] perm [256];
    logic [7:0] swap;
    int         j;
    write_reg(ADDR_MIN_RUN, 32'd256);
    idle_on = 1'b1;
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < 256; i++) perm[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
        j = $urandom_range(0, i);
        swap = perm[i];
        perm[i] = perm[j];
        perm[j] = swap;
      end
      // Close whatever stream is open so the run starts fresh
      send_byte(perm[0], 1'b1);
      for (int i = 0; i < 256; i++) send_byte(perm[i], (f == 1) && (i == 255));
      if (f == 0) send_byte(perm[$urandom_range(0, 255)], 1'b1);
    end
  endtask

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted run with the oldest expected one
  always @(posedge clk) begin : check_runs
    ubrf_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (runs_pending.size() == 0) begin
        report_mismatch("unexpected run, offset", out_tdata[OFFS_W-1:0], 32'd0);
      end else begin
        want = runs_pending.pop_front();
        if (out_tdata[OFFS_W-1:0] !== want.run_offset)
          report_mismatch("run_offset", out_tdata[OFFS_W-1:0], want.run_offset);
        if (out_tdata[OFFS_W +: LEN_W] !== want.run_length)
          report_mismatch("run_length", 32'(out_tdata[OFFS_W +: LEN_W]),
                          32'(want.run_length));
        if (out_tlast !== want.final_result)
          report_mismatch("final_result", 32'(out_tlast), 32'(want.final_result));
      end
    end
  end

  initial begin
    clear_scan();
    min_run = MIN_RUN_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_runs();
    test_two_results();
    test_short_run_skip();
    test_high_threshold();
    test_random_frames(32'd1, 80, 1'b1);
    test_random_frames(32'd2, 80, 1'b1);
    test_random_frames(32'd5, 80, 1'b1);
    test_random_frames(32'd12, 80, 1'b0);
    test_random_frames(32'd20, 80, 1'b1);
    test_random_frames(32'd511, 80, 1'b1);
    test_random_frames(32'd0, 80, 1'b1);
    test_random_frames(32'($urandom_range(1, 256)), 80, 1'b1);
    test_full_width_runs();
    test_random_frames(32'd3, 80, 1'b0);
    in_tvalid <= 1'b0;
    while (runs_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS unique_byte_run_finder");
    end else begin
      $display("FAIL unique_byte_run_finder");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL unique_byte_run_finder");
    $finish;
  end

endmodule

@@ unique_byte_run_finder.f @@
src/ubrf_pkg.sv
src/ubrf_ram.sv
src/ubrf_core.sv
src/ubrf_outq.sv
src/unique_byte_run_finder.sv
src/ubrf_chk.sv
tb/tb_unique_byte_run_finder.sv
